### hdl/wlmu_pkg.sv
`timescale 1ns / 1ps

package wlmu_pkg;

    // memory geometry
    localparam int PAGE_BITS  = 16;
    localparam int MAX_PAGES  = 4;
    localparam int PAGE_W     = 3;
    localparam int HW_W       = 19;
    localparam int BANKS      = 8;
    localparam int BANK_BITS  = 3;
    localparam int ROW_DEPTH  = (MAX_PAGES << PAGE_BITS) / BANKS;
    localparam int ROW_W      = $clog2(ROW_DEPTH);

    // stream payload widths
    localparam int S_TDATA_W  = 136;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 88;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_STORE = 2'd1,
        OP_GROW  = 2'd2,
        OP_SIZE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_BOUNDS       = 2'd1,
        STAT_GROW_REFUSED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic             clear_en;
        logic [ROW_W-1:0] clear_row;
        logic             accept;
        logic             load_done;
        logic             out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic load_ok;
    } t_dp_status;

endpackage

### hdl/wasm_linear_memory_unit_core.sv
`timescale 1ns / 1ps

// channel     | dir | handshake              | payload
// ------------+-----+------------------------+------------------------------------------
// s_axis      | in  | tvalid / tready        | tuser: operation; tdata: access operands
// m_axis      | out | tvalid / tready        | tuser: status; tdata: load data, size, mark
// cfg         | in  | wr_en (no wait)        | initial page count, 3 bits
//
// load in bounds: registered read of the eight byte banks, then the result register
// store, grow, size query and refused loads: result registered at once from the request
// after reset a clearing pass zeroes one row of all banks per cycle over all 32768 rows,
// no transaction is taken meanwhile (config writes are)
// a new transaction is taken while the last result is being taken on m_axis

module wasm_linear_memory_unit_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config
    input  logic                            i_cfg_wr_en,
    input  logic [2:0]                      i_cfg_wr_data,
    // request stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // size_code[1:0], sign_extend[2], wide_result[3], base_address[35:4],
    // address_offset[67:36], store_value[131:68], grow_pages[134:132], zero pad[135]
    input  logic [wlmu_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // operation[1:0]
    input  logic [wlmu_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    // response stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // load_data[63:0], size_pages[66:64], high_water[85:67], zero pad[87:86]
    output logic [wlmu_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // status[1:0]
    output logic [wlmu_pkg::M_TUSER_W-1:0]  o_m_axis_tuser
);

    import wlmu_pkg::*;

    t_ctrl_cmd         w_cmd;
    t_dp_status        w_dp_status;
    logic [63:0]       w_load_data;
    logic [1:0]        w_status;
    logic [PAGE_W-1:0] w_size_pages;
    logic [HW_W-1:0]   w_high_water;

    // sequencing: clearing pass, accept, load wait, result valid
    wlmu_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_dp_status     (w_dp_status),
        .o_cmd           (w_cmd)
    );

    // address maths, byte banks, page count, high-water mark, result register
    wlmu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (w_cmd),
        .o_dp_status      (w_dp_status),
        .i_operation      (i_s_axis_tuser[1:0]),
        .i_size_code      (i_s_axis_tdata[1:0]),
        .i_sign_extend    (i_s_axis_tdata[2]),
        .i_wide_result    (i_s_axis_tdata[3]),
        .i_base_address   (i_s_axis_tdata[35:4]),
        .i_address_offset (i_s_axis_tdata[67:36]),
        .i_store_value    (i_s_axis_tdata[131:68]),
        .i_grow_pages     (i_s_axis_tdata[134:132]),
        .o_load_data      (w_load_data),
        .o_status         (w_status),
        .o_size_pages     (w_size_pages),
        .o_high_water     (w_high_water)
    );

    assign o_m_axis_tdata = {2'b00, w_high_water, w_size_pages, w_load_data};
    assign o_m_axis_tuser = w_status;

    // an in-bounds load always moves to the read-data cycle
    a_load_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_dp_status.load_ok) |=> w_cmd.load_done)
        else $error("in-bounds load did not enter the read cycle");

    // nothing is taken while a load waits for its bank data
    a_no_accept_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_done |-> !o_s_axis_tready)
        else $error("transaction taken during load read");

    // a refused access never returns data
    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == STAT_BOUNDS)) |->
            (o_m_axis_tdata[63:0] == 64'd0))
        else $error("refused access returned data");

    // reported page count stays within one and the maximum
    a_pages_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((o_m_axis_tdata[66:64] != 3'd0) &&
                             (o_m_axis_tdata[66:64] <= 3'(MAX_PAGES))))
        else $error("page count out of range");

endmodule

### hdl/wlmu_ram.sv
`timescale 1ns / 1ps

module wlmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/wlmu_ctrl.sv
`timescale 1ns / 1ps

module wlmu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  wlmu_pkg::t_dp_status  i_dp_status,
    output wlmu_pkg::t_ctrl_cmd   o_cmd
);

    import wlmu_pkg::*;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_clear_row, n_clear_row;
    logic             r_out_valid, n_out_valid;
    logic             w_ready;
    logic             w_accept;
    logic             w_clear_last;

    assign w_clear_last = (r_clear_row == ROW_W'(ROW_DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (w_clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept && i_dp_status.load_ok) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        w_ready         = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
        w_accept        = i_s_axis_tvalid && w_ready;
        o_cmd.clear_en  = (r_state == S_CLEAR);
        o_cmd.clear_row = r_clear_row;
        o_cmd.accept    = w_accept;
        o_cmd.load_done = (r_state == S_LOAD);
        o_cmd.out_load  = (w_accept && !i_dp_status.load_ok) || (r_state == S_LOAD);
        n_clear_row     = (r_state == S_CLEAR) ? r_clear_row + ROW_W'(1) : r_clear_row;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clear_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clear_row <= n_clear_row;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_axis_tready = w_ready;
    assign o_m_axis_tvalid = r_out_valid;

endmodule

### hdl/wlmu_dp.sv
`timescale 1ns / 1ps

module wlmu_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [2:0]                   i_cfg_wr_data,
    input  wlmu_pkg::t_ctrl_cmd          i_cmd,
    output wlmu_pkg::t_dp_status         o_dp_status,
    input  logic [1:0]                   i_operation,
    input  logic [1:0]                   i_size_code,
    input  logic                         i_sign_extend,
    input  logic                         i_wide_result,
    input  logic [31:0]                  i_base_address,
    input  logic [31:0]                  i_address_offset,
    input  logic [63:0]                  i_store_value,
    input  logic [2:0]                   i_grow_pages,
    output logic [63:0]                  o_load_data,
    output logic [1:0]                   o_status,
    output logic [wlmu_pkg::PAGE_W-1:0]  o_size_pages,
    output logic [wlmu_pkg::HW_W-1:0]    o_high_water
);

    import wlmu_pkg::*;

    logic [32:0]         w_ea;
    logic [3:0]          w_width;
    logic [33:0]         w_end;
    logic [33:0]         w_limit;
    logic                w_oob;
    logic                w_store_ok;
    logic [PAGE_W:0]     w_grow_sum;
    logic                w_grow_bad;
    logic [7:0]          w_rd [BANKS];
    logic [63:0]         w_raw;
    logic [63:0]         w_ext;

    logic [PAGE_W-1:0]   r_page_count, n_page_count;
    logic [HW_W-1:0]     r_written_limit, n_written_limit;
    logic [BANK_BITS-1:0] r_ld_off;
    logic [1:0]          r_ld_size;
    logic                r_ld_sext;
    logic                r_ld_wide;
    logic [63:0]         r_load_data;
    logic [1:0]          r_status;
    logic [PAGE_W-1:0]   r_size_pages;
    logic [HW_W-1:0]     r_high_water;

    // effective address and bounds
    assign w_ea       = {1'b0, i_base_address} + {1'b0, i_address_offset};
    assign w_width    = 4'd1 << i_size_code;
    assign w_end      = {1'b0, w_ea} + {30'd0, w_width};
    assign w_limit    = {15'd0, r_page_count, PAGE_BITS'(0)};
    assign w_oob      = (w_end > w_limit);
    assign w_store_ok = i_cmd.accept && (i_operation == OP_STORE) && !w_oob;
    assign w_grow_sum = {1'b0, r_page_count} + {1'b0, i_grow_pages};
    assign w_grow_bad = (w_grow_sum > (PAGE_W + 1)'(MAX_PAGES));

    assign o_dp_status.load_ok = (i_operation == OP_LOAD) && !w_oob;

    // byte lanes: byte a sits in bank a[2:0], row a[17:3]
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        logic [BANK_BITS-1:0] w_lane;
        logic [ROW_W-1:0]     w_row;
        logic                 w_we;
        logic [ROW_W-1:0]     w_waddr;
        logic [7:0]           w_wdata;

        always_comb begin
            w_lane = BANK_BITS'(b) - w_ea[BANK_BITS-1:0];
            w_row  = w_ea[BANK_BITS +: ROW_W]
                   + ROW_W'(BANK_BITS'(b) < w_ea[BANK_BITS-1:0]);
            if (i_cmd.clear_en) begin
                w_we    = 1'b1;
                w_waddr = i_cmd.clear_row;
                w_wdata = 8'd0;
            end else begin
                w_we    = w_store_ok && ({1'b0, w_lane} < w_width);
                w_waddr = w_row;
                w_wdata = i_store_value[{w_lane, 3'b000} +: 8];
            end
        end

        wlmu_ram #(
            .WIDTH (8),
            .DEPTH (ROW_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (w_wdata),
            .i_raddr (w_row),
            .o_rdata (w_rd[b])
        );
    end

    // rotate banks back into access order, then extend
    always_comb begin
        logic [BANK_BITS-1:0] idx;
        w_raw = '0;
        for (int i = 0; i < BANKS; i++) begin
            idx = BANK_BITS'(i) + r_ld_off;
            w_raw[8*i +: 8] = w_rd[idx];
        end
        unique case (r_ld_size)
            2'd0:    w_ext = r_ld_sext ? {{56{w_raw[7]}},  w_raw[7:0]}  : {56'd0, w_raw[7:0]};
            2'd1:    w_ext = r_ld_sext ? {{48{w_raw[15]}}, w_raw[15:0]} : {48'd0, w_raw[15:0]};
            2'd2:    w_ext = r_ld_sext ? {{32{w_raw[31]}}, w_raw[31:0]} : {32'd0, w_raw[31:0]};
            default: w_ext = w_raw;
        endcase
        if (!r_ld_wide) begin
            w_ext[63:32] = 32'd0;
        end
    end

    // architectural state update
    always_comb begin
        n_page_count    = r_page_count;
        n_written_limit = r_written_limit;
        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data == 3'd0) begin
                n_page_count = PAGE_W'(1);
            end else if (i_cfg_wr_data > 3'(MAX_PAGES)) begin
                n_page_count = PAGE_W'(MAX_PAGES);
            end else begin
                n_page_count = PAGE_W'(i_cfg_wr_data);
            end
        end else if (i_cmd.accept && (i_operation == OP_GROW) && !w_grow_bad) begin
            n_page_count = w_grow_sum[PAGE_W-1:0];
        end
        if (w_store_ok && (w_end > {15'd0, r_written_limit})) begin
            n_written_limit = w_end[HW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count    <= PAGE_W'(1);
            r_written_limit <= '0;
        end else begin
            r_page_count    <= n_page_count;
            r_written_limit <= n_written_limit;
        end
    end

    // load context and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ld_off  <= w_ea[BANK_BITS-1:0];
            r_ld_size <= i_size_code;
            r_ld_sext <= i_sign_extend;
            r_ld_wide <= i_wide_result;
        end
        if (i_cmd.load_done) begin
            r_load_data  <= w_ext;
            r_status     <= STAT_OK;
            r_size_pages <= r_page_count;
            r_high_water <= r_written_limit;
        end else if (i_cmd.out_load) begin
            r_load_data  <= 64'd0;
            r_size_pages <= n_page_count;
            r_high_water <= n_written_limit;
            if (((i_operation == OP_LOAD) || (i_operation == OP_STORE)) && w_oob) begin
                r_status <= STAT_BOUNDS;
            end else if ((i_operation == OP_GROW) && w_grow_bad) begin
                r_status <= STAT_GROW_REFUSED;
            end else begin
                r_status <= STAT_OK;
            end
        end
    end

    assign o_load_data  = r_load_data;
    assign o_status     = r_status;
    assign o_size_pages = r_size_pages;
    assign o_high_water = r_high_water;

endmodule
